// ===== rtl/tlsch_pkg.sv =====
// Package for the TLS ClientHello SNI/ALPN parser: item types, codes, constants.
// Used by every module under rtl/.
package tlsch_pkg;

  localparam logic [15:0] MaxRecordLenRst = 16'd18432;
  localparam logic [23:0] MaxHelloLenRst  = 24'd1048576;

  localparam logic [1:0] KindSni     = 2'd0;
  localparam logic [1:0] KindAlpn    = 2'd1;
  localparam logic [1:0] KindVerdict = 2'd2;

  localparam logic [1:0] StParsed  = 2'd0;
  localparam logic [1:0] StNeed    = 2'd1;
  localparam logic [1:0] StNoMatch = 2'd2;
  localparam logic [1:0] StMal     = 2'd3;

  localparam logic [1:0] CauseNone     = 2'd0;
  localparam logic [1:0] CauseRecord   = 2'd1;
  localparam logic [1:0] CauseHello    = 2'd2;
  localparam logic [1:0] CauseMisalign = 2'd3;

  localparam logic CmdData = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  localparam logic [1:0] RegMaxRecord = 2'd0;
  localparam logic [1:0] RegMaxHello  = 2'd1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic        name_end;
    logic [1:0]  status;
    logic [1:0]  error_cause;
    logic [15:0] client_version;
    logic        last_in_step;
  } out_item_t;

  // result pair of one step
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t r0;
    out_item_t r1;
  } step_res_t;

  typedef struct packed {
    logic [15:0] max_record_length;
    logic [23:0] max_hello_length;
  } cfg_t;

endpackage

// ===== rtl/tlsch_regs.sv =====
// APB-style register file for the two length limits.
// Depends on tlsch_pkg.
module tlsch_regs import tlsch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;
  logic [1:0] idx;
  assign idx = paddr[2] ? RegMaxHello : RegMaxRecord;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_record_length <= MaxRecordLenRst;
      cfg_q.max_hello_length  <= MaxHelloLenRst;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegMaxRecord: cfg_q.max_record_length <= pwdata[15:0];
        RegMaxHello:  cfg_q.max_hello_length  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMaxRecord: prdata = {16'd0, cfg_q.max_record_length};
      RegMaxHello:  prdata = {8'd0, cfg_q.max_hello_length};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

// ===== rtl/tlsch_core.sv =====
// Parser state machine: record layer, handshake header and hello body walk.
// One byte per cycle while en_i is high; emits up to two results per byte. Depends on tlsch_pkg.
module tlsch_core import tlsch_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output step_res_t res_o
);
  typedef enum logic [4:0] {
    PhFixed, PhSessLen, PhSessSkip, PhCiphLen, PhCiphSkip, PhCompLen, PhCompSkip,
    PhExtsLen, PhExtHdr, PhExtSkip, PhSniListLen, PhSniEntHdr, PhSniEntSkip,
    PhSniName, PhAlpnListLen, PhAlpnLen, PhAlpnName, PhDone
  } phase_e;

  logic [2:0]  rph_q, rph_d;
  logic [31:0] rhdr_q, rhdr_d;   // first four header bytes are enough
  logic [15:0] rrem_q, rrem_d;
  logic        pseen_q, pseen_d;
  logic [31:0] hhdr_q, hhdr_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [23:0] hrem_q, hrem_d;
  phase_e      ph_q, ph_d;
  logic [5:0]  fo_q, fo_d;
  logic [15:0] frem_q, frem_d, exsr_q, exsr_d, exr_q, exr_d, lrem_q, lrem_d;
  logic [15:0] va_q, va_d, etype_q, etype_d, ver_q, ver_d;
  logic [7:0]  entt_q, entt_d;
  logic [4:0]  pend_q, pend_d;
  logic        given_q, given_d;

  // locals of the step
  logic [7:0]  b;
  logic [39:0] hdr5;
  logic [15:0] v16, len;
  logic [31:0] hh;
  logic        hdr_ok;
  step_res_t   r;

  function automatic out_item_t mk(logic [1:0] k, logic [7:0] nb, logic ne,
                                   logic [1:0] st, logic [1:0] c, logic [15:0] ve);
    out_item_t o;
    o.kind = k; o.name_byte = nb; o.name_end = ne; o.status = st;
    o.error_cause = c; o.client_version = ve; o.last_in_step = 1'b0;
    return o;
  endfunction

  always_comb begin
    rph_d = rph_q; rhdr_d = rhdr_q; rrem_d = rrem_q; pseen_d = pseen_q;
    hhdr_d = hhdr_q; hcnt_d = hcnt_q; hrem_d = hrem_q; ph_d = ph_q; fo_d = fo_q;
    frem_d = frem_q; exsr_d = exsr_q; exr_d = exr_q; lrem_d = lrem_q;
    va_d = va_q; etype_d = etype_q; entt_d = entt_q; ver_d = ver_q;
    pend_d = pend_q; given_d = given_q;
    r = '0;
    b = item_i.data_byte;
    hdr5 = {rhdr_q, b};
    v16 = '0; len = '0; hh = '0; hdr_ok = 1'b0;

    if (item_i.cmd == CmdEnd) begin
      if (!given_q) begin
        r.v0 = 1'b1; r.r0 = mk(KindVerdict, 8'd0, 1'b0, StNeed, CauseNone, 16'd0);
      end
      rph_d = '0; rhdr_d = '0; rrem_d = '0; pseen_d = 1'b0; hhdr_d = '0; hcnt_d = '0;
      hrem_d = '0; ph_d = PhFixed; fo_d = '0; frem_d = '0; exsr_d = '0; exr_d = '0;
      lrem_d = '0; va_d = '0; etype_d = '0; entt_d = '0; ver_d = '0; pend_d = '0;
      given_d = 1'b0;
    end else if (!given_q) begin
      if (rph_q < 3'd5) begin
        rhdr_d = hdr5[31:0];
        rph_d = rph_q + 3'd1;
        if (rph_q == 3'd4) begin
          len = hdr5[15:0];
          if (hdr5[39:32] != 8'd22 || hdr5[31:24] != 8'd3) begin
            r.v0 = 1'b1; given_d = 1'b1;
            r.r0 = mk(KindVerdict, 8'd0, 1'b0, pseen_q ? StMal : StNoMatch, CauseNone, 16'd0);
          end else if (len > cfg_i.max_record_length) begin
            r.v0 = 1'b1; given_d = 1'b1;
            r.r0 = mk(KindVerdict, 8'd0, 1'b0, StMal, CauseRecord, 16'd0);
          end else begin
            rrem_d = len;
          end
        end
      end else begin
        if (rrem_q != 0) rrem_d = rrem_q - 16'd1;
        pseen_d = 1'b1;
        if (hcnt_q < 3'd4) begin
          hhdr_d = {hhdr_q[23:0], b};
          hcnt_d = hcnt_q + 3'd1;
          if (hcnt_q == 3'd3) hrem_d = {hhdr_q[15:0], b};
        end else if (hrem_q != 0) begin
          hrem_d = hrem_q - 24'd1;
          if (hhdr_q[31:24] == 8'd1 && hhdr_q[23:0] <= cfg_i.max_hello_length
              && ph_q != PhDone) begin
            // body walk; hrem_d is the decremented remaining length
            unique case (ph_q)
              PhFixed: begin
                if (fo_q < 6'd2) ver_d = {ver_q[7:0], b};
                fo_d = fo_q + 6'd1;
                if (fo_q == 6'd33) begin fo_d = '0; ph_d = PhSessLen; end
              end
              PhSessLen: begin
                if ({16'd0, b} > hrem_d) begin pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone; end
                else begin
                  frem_d = {8'd0, b}; fo_d = '0;
                  ph_d = (b != 0) ? PhSessSkip : PhCiphLen;
                end
              end
              PhSessSkip: begin
                if (frem_q <= 16'd1) begin frem_d = '0; fo_d = '0; ph_d = PhCiphLen; end
                else frem_d = frem_q - 16'd1;
              end
              PhCiphLen: begin
                va_d = {va_q[7:0], b};
                if (fo_q == 6'd0) fo_d = 6'd1;
                else begin
                  fo_d = '0;
                  v16 = {va_q[7:0], b};
                  if (v16 == 0 || v16[0] || {8'd0, v16} > hrem_d) begin
                    pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone;
                  end else begin frem_d = v16; ph_d = PhCiphSkip; end
                end
              end
              PhCiphSkip: begin
                if (frem_q <= 16'd1) begin frem_d = '0; ph_d = PhCompLen; end
                else frem_d = frem_q - 16'd1;
              end
              PhCompLen: begin
                if ({16'd0, b} > hrem_d) begin pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone; end
                else if (b == 0) begin
                  fo_d = '0;
                  if (hrem_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                  else ph_d = PhExtsLen;
                end else begin frem_d = {8'd0, b}; ph_d = PhCompSkip; end
              end
              PhCompSkip: begin
                if (frem_q <= 16'd1) begin
                  frem_d = '0; fo_d = '0;
                  if (hrem_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                  else ph_d = PhExtsLen;
                end else frem_d = frem_q - 16'd1;
              end
              PhExtsLen: begin
                va_d = {va_q[7:0], b};
                if (fo_q == 6'd0) fo_d = 6'd1;
                else begin
                  fo_d = '0;
                  v16 = {va_q[7:0], b};
                  if ({8'd0, v16} > hrem_d) begin pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone; end
                  else begin
                    exsr_d = v16;
                    if (v16 == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                    else if (v16 < 16'd4) begin pend_d = {1'b1, StMal, CauseMisalign}; ph_d = PhDone; end
                    else ph_d = PhExtHdr;
                  end
                end
              end
              PhDone: ;
              default: begin
                // extension block
                if (exsr_q != 0) exsr_d = exsr_q - 16'd1;
                if (ph_q == PhExtHdr) begin
                  va_d = {va_q[7:0], b};
                  fo_d = fo_q + 6'd1;
                  if (fo_q == 6'd1) etype_d = {va_q[7:0], b};
                  if (fo_q == 6'd3) begin
                    fo_d = '0;
                    v16 = {va_q[7:0], b};
                    if (v16 > exsr_d) begin pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone; end
                    else begin
                      exr_d = v16;
                      if (etype_q == 16'd0 && v16 >= 16'd5) ph_d = PhSniListLen;
                      else if (etype_q == 16'd16 && v16 >= 16'd3) ph_d = PhAlpnListLen;
                      else if (v16 != 0) ph_d = PhExtSkip;
                      else if (exsr_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                      else if (exsr_d < 16'd4) begin pend_d = {1'b1, StMal, CauseMisalign}; ph_d = PhDone; end
                      else ph_d = PhExtHdr;
                    end
                  end
                end else begin
                  if (exr_q != 0) exr_d = exr_q - 16'd1;
                  if (ph_q == PhExtSkip) begin
                    if (exr_d == 0) begin
                      fo_d = '0;
                      if (exsr_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                      else if (exsr_d < 16'd4) begin pend_d = {1'b1, StMal, CauseMisalign}; ph_d = PhDone; end
                      else ph_d = PhExtHdr;
                    end
                  end else if (ph_q == PhSniListLen || ph_q == PhAlpnListLen) begin
                    va_d = {va_q[7:0], b};
                    if (fo_q == 6'd0) fo_d = 6'd1;
                    else begin
                      fo_d = '0;
                      v16 = {va_q[7:0], b};
                      if (v16 > exr_d) begin pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone; end
                      else begin
                        lrem_d = v16;
                        if ((ph_q == PhSniListLen && v16 >= 16'd3)
                            || (ph_q == PhAlpnListLen && v16 != 0))
                          ph_d = (ph_q == PhSniListLen) ? PhSniEntHdr : PhAlpnLen;
                        else if (exr_d != 0) ph_d = PhExtSkip;
                        else if (exsr_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                        else if (exsr_d < 16'd4) begin pend_d = {1'b1, StMal, CauseMisalign}; ph_d = PhDone; end
                        else ph_d = PhExtHdr;
                      end
                    end
                  end else begin
                    if (lrem_q != 0) lrem_d = lrem_q - 16'd1;
                    v16 = '0;
                    unique case (ph_q)
                      PhSniEntHdr: begin
                        fo_d = fo_q + 6'd1;
                        if (fo_q == 6'd0) begin entt_d = b; va_d = '0; end
                        else begin
                          va_d = {va_q[7:0], b};
                          if (fo_q == 6'd2) begin
                            fo_d = '0;
                            v16 = {va_q[7:0], b};
                            if (v16 > lrem_d) begin pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone; end
                            else if (v16 != 0) begin
                              frem_d = v16;
                              ph_d = (entt_q == 8'd0) ? PhSniName : PhSniEntSkip;
                            end else if (lrem_d >= 16'd3) ph_d = PhSniEntHdr;
                            else if (exr_d != 0) ph_d = PhExtSkip;
                            else if (exsr_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                            else if (exsr_d < 16'd4) begin pend_d = {1'b1, StMal, CauseMisalign}; ph_d = PhDone; end
                            else ph_d = PhExtHdr;
                          end
                        end
                      end
                      PhSniEntSkip: begin
                        frem_d = (frem_q != 0) ? frem_q - 16'd1 : '0;
                        if (frem_q <= 16'd1) begin
                          fo_d = '0;
                          if (lrem_d >= 16'd3) ph_d = PhSniEntHdr;
                          else if (exr_d != 0) ph_d = PhExtSkip;
                          else if (exsr_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                          else if (exsr_d < 16'd4) begin pend_d = {1'b1, StMal, CauseMisalign}; ph_d = PhDone; end
                          else ph_d = PhExtHdr;
                        end
                      end
                      PhSniName: begin
                        frem_d = (frem_q != 0) ? frem_q - 16'd1 : '0;
                        if (b < 8'h21 || b > 8'h7e) begin
                          pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone;
                        end else begin
                          r.v0 = 1'b1;
                          r.r0 = mk(KindSni, b, frem_q <= 16'd1, StParsed, CauseNone, 16'd0);
                          if (frem_q <= 16'd1) begin
                            if (exr_d != 0) ph_d = PhExtSkip;
                            else begin
                              fo_d = '0;
                              if (exsr_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                              else if (exsr_d < 16'd4) begin pend_d = {1'b1, StMal, CauseMisalign}; ph_d = PhDone; end
                              else ph_d = PhExtHdr;
                            end
                          end
                        end
                      end
                      PhAlpnLen: begin
                        if (b == 0 || {8'd0, b} > lrem_d) begin
                          pend_d = {1'b1, StMal, CauseNone}; ph_d = PhDone;
                        end else begin frem_d = {8'd0, b}; ph_d = PhAlpnName; end
                      end
                      PhAlpnName: begin
                        frem_d = (frem_q != 0) ? frem_q - 16'd1 : '0;
                        r.v0 = 1'b1;
                        r.r0 = mk(KindAlpn, b, frem_q <= 16'd1, StParsed, CauseNone, 16'd0);
                        if (frem_q <= 16'd1) begin
                          if (lrem_d != 0) ph_d = PhAlpnLen;
                          else if (exr_d != 0) ph_d = PhExtSkip;
                          else begin
                            fo_d = '0;
                            if (exsr_d == 0) begin pend_d = {1'b1, StParsed, CauseNone}; ph_d = PhDone; end
                            else if (exsr_d < 16'd4) begin pend_d = {1'b1, StMal, CauseMisalign}; ph_d = PhDone; end
                            else ph_d = PhExtHdr;
                          end
                        end
                      end
                      default: ph_d = PhDone;
                    endcase
                  end
                end
              end
            endcase
          end
        end
        // record end after this payload byte
        if (rrem_q <= 16'd1) begin
          rph_d = '0;
          hh = hhdr_d;
          hdr_ok = 1'b1;
          if (hcnt_d == 3'd4) begin
            if (hh[31:24] != 8'd1) begin
              given_d = 1'b1; r.v1 = 1'b1;
              r.r1 = mk(KindVerdict, 8'd0, 1'b0, StNoMatch, CauseNone, 16'd0);
            end else if (hh[23:0] > cfg_i.max_hello_length) begin
              given_d = 1'b1; r.v1 = 1'b1;
              r.r1 = mk(KindVerdict, 8'd0, 1'b0, StMal, CauseHello, 16'd0);
            end else if (hrem_d == 0) begin
              given_d = 1'b1; r.v1 = 1'b1;
              if (pend_d[4])
                r.r1 = mk(KindVerdict, 8'd0, 1'b0, pend_d[3:2], pend_d[1:0],
                          (pend_d[3:2] == StParsed) ? ver_d : 16'd0);
              else
                r.r1 = mk(KindVerdict, 8'd0, 1'b0, StMal, CauseNone, 16'd0);
            end
          end
        end
      end
      // zero-length record: record end right on the header
      if (rph_q == 3'd4 && !r.v0 && hdr5[15:0] == 16'd0) begin
        rph_d = '0;
        if (hcnt_q == 3'd4) begin
          if (hhdr_q[31:24] != 8'd1) begin
            given_d = 1'b1; r.v1 = 1'b1;
            r.r1 = mk(KindVerdict, 8'd0, 1'b0, StNoMatch, CauseNone, 16'd0);
          end else if (hhdr_q[23:0] > cfg_i.max_hello_length) begin
            given_d = 1'b1; r.v1 = 1'b1;
            r.r1 = mk(KindVerdict, 8'd0, 1'b0, StMal, CauseHello, 16'd0);
          end else if (hrem_q == 0) begin
            given_d = 1'b1; r.v1 = 1'b1;
            if (pend_q[4])
              r.r1 = mk(KindVerdict, 8'd0, 1'b0, pend_q[3:2], pend_q[1:0],
                        (pend_q[3:2] == StParsed) ? ver_q : 16'd0);
            else
              r.r1 = mk(KindVerdict, 8'd0, 1'b0, StMal, CauseNone, 16'd0);
          end
        end
      end
    end
    // pack: compact to slot 0 first, mark last
    if (!r.v0 && r.v1) begin r.v0 = 1'b1; r.r0 = r.r1; r.v1 = 1'b0; end
    if (r.v1) r.r1.last_in_step = 1'b1;
    else if (r.v0) r.r0.last_in_step = 1'b1;
    if (!hdr_ok) hh = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rph_q <= '0; rrem_q <= '0; pseen_q <= 1'b0; hcnt_q <= '0; hrem_q <= '0;
      ph_q <= PhFixed; fo_q <= '0; frem_q <= '0; exsr_q <= '0; exr_q <= '0;
      lrem_q <= '0; pend_q <= '0; given_q <= 1'b0;
      rhdr_q <= '0; hhdr_q <= '0; va_q <= '0; etype_q <= '0; entt_q <= '0; ver_q <= '0;
    end else if (en_i) begin
      rph_q <= rph_d; rrem_q <= rrem_d; pseen_q <= pseen_d; hcnt_q <= hcnt_d;
      hrem_q <= hrem_d; ph_q <= ph_d; fo_q <= fo_d; frem_q <= frem_d;
      exsr_q <= exsr_d; exr_q <= exr_d; lrem_q <= lrem_d; pend_q <= pend_d;
      given_q <= given_d; rhdr_q <= rhdr_d; hhdr_q <= hhdr_d; va_q <= va_d;
      etype_q <= etype_d; entt_q <= entt_d; ver_q <= ver_d;
    end
  end

  assign res_o = r;

`ifndef SYNTHESIS
  a_rph_range: assert property (@(posedge clk_i) disable iff (!rst_ni) rph_q <= 3'd5)
    else $error("record phase out of range");
  a_hcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) hcnt_q <= 3'd4)
    else $error("handshake header count out of range");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.cmd == CmdEnd |=> !given_q && rph_q == 3'd0)
    else $error("end of stream did not clear state");
`endif
endmodule

// ===== rtl/tlsch_outq.sv =====
// Output queue: takes a step's one or two results, drains one per cycle while ready_i is high.
// Depends on tlsch_pkg.
module tlsch_outq import tlsch_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  step_res_t res_i,
  output logic      room_o,
  output logic      valid_o,
  output out_item_t item_o,
  input  logic      ready_i
);
  out_item_t  buf_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] npush;

  assign pop = valid_o && ready_i;
  assign npush = push_i ? ({1'b0, res_i.v0} + {1'b0, res_i.v1}) : 2'd0;
  assign valid_o = cnt_q != 3'd0;
  assign item_o = buf_q[rd_q];
  // room for two after this cycle's pop
  assign room_o = (cnt_q - {2'd0, pop}) <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (push_i && res_i.v0) buf_q[wr_q] <= res_i.r0;
    if (push_i && res_i.v1) buf_q[wr_q + 2'd1] <= res_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_q + npush;
      rd_q <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, npush} - {2'd0, pop};
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("output queue overflow");
  a_nopush_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o) else $error("push without room");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && res_i.v1 |-> res_i.v0) else $error("result slots out of order");
`endif
endmodule

// ===== rtl/tls_client_hello_sni_alpn_parser_unit.sv =====
// TLS ClientHello SNI/ALPN parser, top level.
// Results of an accepted byte are written into the output queue and leave from its head.
// Throughput: one byte per cycle while the queue has room for two; a byte giving two results
// drains one result at a time through the single-read output queue (four entries).
// Reset: asynchronous active low; stream state cleared, limits to 18432 and 1048576.
// Depends on tlsch_pkg, tlsch_regs, tlsch_core, tlsch_outq.
module tls_client_hello_sni_alpn_parser_unit import tlsch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t      cfg;
  step_res_t res;
  logic      acc;

  tlsch_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // byte accepted whenever the queue can absorb a worst-case pair of results
  assign acc = in_valid_i && in_ready_o;

  tlsch_core u_core (
    .clk_i, .rst_ni, .en_i(acc), .item_i(in_item_i), .cfg_i(cfg), .res_o(res)
  );

  tlsch_outq u_outq (
    .clk_i, .rst_ni, .push_i(acc), .res_i(res), .room_o(in_ready_o),
    .valid_o(out_valid_o), .item_o(out_item_o), .ready_i(out_ready_i)
  );
endmodule
